// File: sv/cawf_pkg.sv
package cawf_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_ADC   = 4'd1,
    KIND_SUB   = 4'd2,
    KIND_SBC   = 4'd3,
    KIND_AND   = 4'd4,
    KIND_XOR   = 4'd5,
    KIND_OR    = 4'd6,
    KIND_INC8  = 4'd7,
    KIND_DEC8  = 4'd8,
    KIND_ADD16 = 4'd9,
    KIND_SPOFS = 4'd10,
    KIND_INC16 = 4'd11,
    KIND_DEC16 = 4'd12
  } kind_e;

  // Bit positions in the Z N H C flag nibble
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam int unsigned DataW  = 16;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 24;

  // One operation request as held in the input register
  typedef struct packed {
    kind_e              kind;
    logic [DataW-1:0]   dest_value;
    logic [DataW-1:0]   operand;
    logic [FlagW-1:0]   flags_in;
  } alu_req_t;

  // One result as held in the result register
  typedef struct packed {
    logic [DataW-1:0]   result;
    logic [FlagW-1:0]   flags_out;
  } alu_rsp_t;

endpackage

// File: sv/cawf_alu.sv
module cawf_alu
  import cawf_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  and8;
  logic [7:0]  xor8;
  logic [7:0]  or8;
  logic [15:0] spofs;
  logic [15:0] res;
  logic [3:0]  flg;

  assign a   = req_i.dest_value[7:0];
  assign b   = req_i.operand[7:0];
  // carry only enters for adc and sbc
  assign cin = req_i.flags_in[FLAG_C] &
               ((req_i.kind == KIND_ADC) | (req_i.kind == KIND_SBC));

  // 8-bit adder and subtractor with nibble halves for H
  assign add9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign sub9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign subh = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

  // 16-bit add with carry out of bit 11 for H
  assign add17 = {1'b0, req_i.dest_value} + {1'b0, req_i.operand};
  assign add13 = {1'b0, req_i.dest_value[11:0]} + {1'b0, req_i.operand[11:0]};

  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;
  assign and8  = a & b;
  assign xor8  = a ^ b;
  assign or8   = a | b;
  // stack pointer plus sign-extended byte
  assign spofs = req_i.dest_value + {{8{b[7]}}, b};

  // Result and flag select
  always_comb begin
    res = req_i.dest_value;
    flg = req_i.flags_in;
    unique case (req_i.kind) inside
      KIND_ADD, KIND_ADC: begin
        res = {8'd0, add9[7:0]};
        flg[FLAG_Z] = (add9[7:0] == 8'd0);
        flg[FLAG_N] = 1'b0;
        flg[FLAG_H] = addh[4];
        flg[FLAG_C] = add9[8];
      end
      KIND_SUB, KIND_SBC: begin
        res = {8'd0, sub9[7:0]};
        flg[FLAG_Z] = (sub9[7:0] == 8'd0);
        flg[FLAG_N] = 1'b1;
        flg[FLAG_H] = subh[4];
        flg[FLAG_C] = sub9[8];
      end
      KIND_AND, KIND_XOR, KIND_OR: begin
        if (req_i.kind == KIND_AND) begin
          res = {8'd0, and8};
        end else if (req_i.kind == KIND_XOR) begin
          res = {8'd0, xor8};
        end else begin
          res = {8'd0, or8};
        end
        flg[FLAG_Z] = (res[7:0] == 8'd0);
        flg[FLAG_N] = 1'b0;
        flg[FLAG_H] = (req_i.kind == KIND_AND);
        flg[FLAG_C] = 1'b0;
      end
      KIND_INC8: begin
        res = {8'd0, inc8};
        flg[FLAG_Z] = (inc8 == 8'd0);
        flg[FLAG_N] = 1'b0;
        flg[FLAG_H] = (inc8[3:0] == 4'h0);
      end
      KIND_DEC8: begin
        res = {8'd0, dec8};
        flg[FLAG_Z] = (dec8 == 8'd0);
        flg[FLAG_N] = 1'b1;
        flg[FLAG_H] = (dec8[3:0] == 4'hF);
      end
      KIND_ADD16: begin
        res = add17[15:0];
        flg[FLAG_N] = 1'b0;
        flg[FLAG_H] = add13[12];
        flg[FLAG_C] = add17[16];
      end
      KIND_SPOFS: begin
        // H and C come from the unsigned low-byte add (no carry in)
        res = spofs;
        flg[FLAG_Z] = 1'b0;
        flg[FLAG_N] = 1'b0;
        flg[FLAG_H] = addh[4];
        flg[FLAG_C] = add9[8];
      end
      KIND_INC16: res = req_i.dest_value + 16'd1;
      KIND_DEC16: res = req_i.dest_value - 16'd1;
      default: begin
        // unused codes pass value and flags through
        res = req_i.dest_value;
        flg = req_i.flags_in;
      end
    endcase
  end

  assign rsp_o.result    = res;
  assign rsp_o.flags_out = flg;

endmodule

// File: sv/cpu_alu_with_flags_core.sv
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   dest_value[15:0] operand[31:16]              kind[3:0]
//                flags_in[35:32] zero[39:36]
// m_axis    out  result[15:0] flags_out[19:16] zero[23:20]    -
//
// One request per cycle, sustained while the result side is not stalled; a
// request passes through the input register, one ALU pass and the result register.
// Reset clears both valid bits; the payload registers are not reset.
// A stalled result holds in the result register while the input register
// can still take one more request; s_axis_tready falls only when both are full.
module cpu_alu_with_flags_core
  import cawf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // dest_value, operand, flags_in
  input  logic [3:0]           s_axis_tuser,  // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata   // result, flags_out
);

  logic     in_valid_q;
  alu_req_t in_req_q;
  alu_req_t in_req_d;
  logic     out_valid_q;
  alu_rsp_t out_rsp_q;
  alu_rsp_t alu_rsp;
  logic     out_ready;
  logic     in_ready;

  // Stage handshakes: each register loads when empty or draining
  assign out_ready     = ~out_valid_q | m_axis_tready;
  assign in_ready      = ~in_valid_q | out_ready;
  assign s_axis_tready = in_ready;

  // Unpack the request
  assign in_req_d.kind       = kind_e'(s_axis_tuser);
  assign in_req_d.dest_value = s_axis_tdata[15:0];
  assign in_req_d.operand    = s_axis_tdata[31:16];
  assign in_req_d.flags_in   = s_axis_tdata[35:32];

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_req_q <= in_req_d;
    end
  end

  cawf_alu u_alu (
    .req_i (in_req_q),
    .rsp_o (alu_rsp)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_rsp_q <= alu_rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_rsp_q.flags_out, out_rsp_q.result};

endmodule

// File: sv/cawf_checker.sv
module cawf_checker
  import cawf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // A stalled result keeps its valid and its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A ready sink never backpressures the request side
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("request stalled with ready sink");

  // A taken request reaches the output if the sink drains while it sits in the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after two cycles");

  // Pad bits of the result are zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutTdataW-1:20] == 4'd0))
    else $error("result pad bits set");

endmodule

bind cpu_alu_with_flags_core cawf_checker u_checker (.*);

// File: bench/tb_cpu_alu_with_flags_core.sv
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags_core;
  import cawf_pkg::*;

  // Kind codes outside the defined set; the block passes these through
  localparam logic [3:0] KIND_UNUSED_LO = 4'd13;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  localparam int unsigned RandomPerPhase = 375;
  localparam int unsigned HoldOffLen     = 60;
  localparam int unsigned MaxPrinted     = 100;

  // Expected-result store with its own ALU/flag predictor
  class alu_scoreboard;
    alu_rsp_t expected_q[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      errors = 0;
      results_seen = 0;
    endfunction

    // Predict result and Z N H C flags for one request
    function alu_rsp_t compute_alu(logic [3:0] k, logic [15:0] d, logic [15:0] o,
                                   logic [3:0] fi);
      alu_rsp_t   rsp;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] r8;
      logic [8:0] s9;
      logic [16:0] s17;
      logic [15:0] r;
      logic [3:0] f;
      logic       cin;
      a   = d[7:0];
      b   = o[7:0];
      f   = fi;
      r   = d;
      cin = fi[FLAG_C];
      case (k)
        KIND_ADD, KIND_ADC: begin
          if (k == KIND_ADD) cin = 1'b0;
          s9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
          r  = {8'h00, s9[7:0]};
          f[FLAG_Z] = (s9[7:0] == 8'h00);
          f[FLAG_N] = 1'b0;
          f[FLAG_H] = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin}) > 5'h0F;
          f[FLAG_C] = s9[8];
        end
        KIND_SUB, KIND_SBC: begin
          if (k == KIND_SUB) cin = 1'b0;
          r8 = a - b - {7'd0, cin};
          r  = {8'h00, r8};
          f[FLAG_Z] = (r8 == 8'h00);
          f[FLAG_N] = 1'b1;
          f[FLAG_H] = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin});
          f[FLAG_C] = {1'b0, a} < ({1'b0, b} + {8'd0, cin});
        end
        KIND_AND, KIND_XOR, KIND_OR: begin
          r8 = (k == KIND_AND) ? (a & b) : (k == KIND_XOR) ? (a ^ b) : (a | b);
          r  = {8'h00, r8};
          f[FLAG_Z] = (r8 == 8'h00);
          f[FLAG_N] = 1'b0;
          f[FLAG_H] = (k == KIND_AND);
          f[FLAG_C] = 1'b0;
        end
        KIND_INC8: begin
          r8 = a + 8'd1;
          r  = {8'h00, r8};
          f[FLAG_Z] = (r8 == 8'h00);
          f[FLAG_N] = 1'b0;
          f[FLAG_H] = (r8[3:0] == 4'h0);
        end
        KIND_DEC8: begin
          r8 = a - 8'd1;
          r  = {8'h00, r8};
          f[FLAG_Z] = (r8 == 8'h00);
          f[FLAG_N] = 1'b1;
          f[FLAG_H] = (r8[3:0] == 4'hF);
        end
        KIND_ADD16: begin
          s17 = {1'b0, d} + {1'b0, o};
          r   = s17[15:0];
          f[FLAG_N] = 1'b0;
          f[FLAG_H] = ({1'b0, d[11:0]} + {1'b0, o[11:0]}) >= 13'h1000;
          f[FLAG_C] = s17[16];
        end
        KIND_SPOFS: begin
          // offset is the sign-extended low operand byte; flags from low-byte add
          r = d + {{8{b[7]}}, b};
          f[FLAG_Z] = 1'b0;
          f[FLAG_N] = 1'b0;
          f[FLAG_H] = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) >= 5'h10;
          f[FLAG_C] = ({1'b0, a} + {1'b0, b}) >= 9'h100;
        end
        KIND_INC16: r = d + 16'd1;
        KIND_DEC16: r = d - 16'd1;
        default: ;
      endcase
      rsp.result    = r;
      rsp.flags_out = f;
      return rsp;
    endfunction

    function void note_request(logic [3:0] k, logic [15:0] d, logic [15:0] o,
                               logic [3:0] fi);
      expected_q.push_back(compute_alu(k, d, o, fi));
    endfunction

    task report(string what);
      if (errors < MaxPrinted) $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted result against the oldest prediction
    task check_result(logic [OutTdataW-1:0] tdata);
      alu_rsp_t    want;
      logic [15:0] got_r;
      logic [3:0]  got_f;
      got_r = tdata[15:0];
      got_f = tdata[19:16];
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending: tdata=%h",
                         results_seen, tdata));
      end else begin
        want = expected_q.pop_front();
        if (got_r !== want.result)
          report($sformatf("result %0d: value %h, expected %h",
                           results_seen, got_r, want.result));
        if (got_f !== want.flags_out)
          report($sformatf("result %0d: flags %b, expected %b",
                           results_seen, got_f, want.flags_out));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // dest_value, operand, flags_in, zero pad
  logic [3:0]           s_axis_tuser;   // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;   // result, flags_out, zero pad

  alu_scoreboard sb;
  int unsigned   req_idle_pct;
  int unsigned   rsp_stall_pct;
  int unsigned   hold_off_cycles;

  cpu_alu_with_flags_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: check accepted results, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_off_cycles > 0) begin
        m_axis_tready   <= 1'b0;
        hold_off_cycles <= hold_off_cycles - 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  // Offer one request; tvalid stays high afterwards so the next one can follow
  task send_op(logic [3:0] k, logic [15:0] d, logic [15:0] o, logic [3:0] fi);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {4'b0000, fi, o, d};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(k, d, o, fi);
  endtask

  // Stop offering and wait until every pending result is back
  task drain;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Mix of corner values and fully random words
  function logic [15:0] pick_word();
    logic [15:0] corners [10];
    corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'h0080, 16'h007F,
                16'h000F, 16'h0010, 16'h0FFF, 16'h1000, 16'hFF00};
    if ($urandom_range(0, 99) < 25) return corners[$urandom_range(0, 9)];
    return 16'($urandom());
  endfunction

  task send_random_op;
    logic [3:0] k;
    if ($urandom_range(0, 99) < 6) k = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    else k = 4'($urandom_range(KIND_ADD, KIND_DEC16));
    send_op(k, pick_word(), pick_word(), 4'($urandom()));
  endtask

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    m_axis_tready   = 1'b0;
    req_idle_pct    = 0;
    rsp_stall_pct   = 0;
    hold_off_cycles = 0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners of every operation
    send_op(KIND_ADD,   16'h00FF, 16'h0001, 4'b0000);  // carry from both nibbles, zero
    send_op(KIND_ADD,   16'hCD34, 16'hAB12, 4'b1111);  // high bytes ignored
    send_op(KIND_ADC,   16'h000F, 16'h0000, 4'b0001);  // half carry from carry-in
    send_op(KIND_ADC,   16'h00FF, 16'h00FF, 4'b0001);
    send_op(KIND_SUB,   16'h003C, 16'h003C, 4'b0000);  // equal operands
    send_op(KIND_SUB,   16'h0010, 16'h0001, 4'b0000);  // nibble borrow
    send_op(KIND_SBC,   16'h0000, 16'h00FF, 4'b0001);  // full borrow with carry-in
    send_op(KIND_SBC,   16'h0000, 16'h0000, 4'b1110);
    send_op(KIND_AND,   16'h00F0, 16'h000F, 4'b0000);
    send_op(KIND_AND,   16'h00FF, 16'h00FF, 4'b0001);
    send_op(KIND_XOR,   16'h005A, 16'h005A, 4'b0111);
    send_op(KIND_OR,    16'h0000, 16'h0000, 4'b0111);
    send_op(KIND_OR,    16'h0080, 16'h0001, 4'b1111);
    send_op(KIND_INC8,  16'hFFFF, 16'h0000, 4'b0001);  // wrap, carry kept
    send_op(KIND_INC8,  16'h000F, 16'h0000, 4'b0000);
    send_op(KIND_DEC8,  16'h0001, 16'h0000, 4'b0000);
    send_op(KIND_DEC8,  16'h0000, 16'h0000, 4'b0001);  // wrap to FF
    send_op(KIND_ADD16, 16'hFFFF, 16'h0001, 4'b1000);  // zero flag kept
    send_op(KIND_ADD16, 16'h0FFF, 16'h0001, 4'b0000);  // bit 11 carry only
    send_op(KIND_SPOFS, 16'hFFFF, 16'h0001, 4'b1111);
    send_op(KIND_SPOFS, 16'h0000, 16'h1280, 4'b0000);  // most negative offset
    send_op(KIND_INC16, 16'hFFFF, 16'h0000, 4'b1111);
    send_op(KIND_DEC16, 16'h0000, 16'hFFFF, 4'b0000);
    send_op(KIND_UNUSED_LO, 16'h1234, 16'h5678, 4'b1010);
    send_op(KIND_UNUSED_HI, 16'hFFFF, 16'hFFFF, 4'b0101);
    drain();

    // Random phases with different idle/stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_idle_pct = 45; rsp_stall_pct = 0;  end
        2: begin req_idle_pct = 0;  rsp_stall_pct = 45; end
        default: begin req_idle_pct = 28; rsp_stall_pct = 28; end
      endcase
      for (int i = 0; i < RandomPerPhase; i++) begin
        // long result-side hold-off while requests keep coming
        if (p == 0 && i == 100) hold_off_cycles <= HoldOffLen;
        send_random_op();
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
